[sv/char_lcd_write_sequencer_assert.svh]
// Assertion macros for the LCD write sequencer; clocked on clk, held off during reset.
`ifndef CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LCDWS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LCDWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LCDWS_ASSERT_IMPLY(label, ante, cons, msg)

`define LCDWS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/lcdws_pkg.sv]
package lcdws_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TICKS_W     = 16;
    localparam int STROBE_W    = 8;
    localparam int BYTE_W      = 8;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FOUR_BIT_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_GAP_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_HOLD_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_HOLD_TICKS    = 3'd4;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hf0;
    localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0f;

    localparam logic              RESET_FOUR_BIT_MODE      = 1'b1;
    localparam logic [STROBE_W-1:0] RESET_ENABLE_HIGH_TICKS = 8'd3;
    localparam logic [TICKS_W-1:0] RESET_NIBBLE_GAP_TICKS   = 16'd200;
    localparam logic [TICKS_W-1:0] RESET_COMMAND_HOLD_TICKS = 16'd3000;
    localparam logic [TICKS_W-1:0] RESET_DATA_HOLD_TICKS    = 16'd3000;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_STROBE_HI = 5'b00010,
        PH_GAP       = 5'b00100,
        PH_STROBE_LO = 5'b01000,
        PH_HOLD      = 5'b10000
    } lcdws_phase_t;

    // Last member lands in the lowest bits of tdata.
    typedef struct packed {
        logic [1:0]        pad;
        logic              write_refused;
        logic              busy_res;
        logic              enable_strobe;
        logic              read_write;
        logic              register_select;
        logic              low_pins_driven;
        logic [BYTE_W-1:0] data_pins;
    } lcdws_result_t;

endpackage

[sv/char_lcd_write_sequencer.sv]
// Character LCD write sequencer.
// Input stream: one transaction per clock at most. s_tuser[0] is the action (0 tick of
// the one-microsecond timebase, 1 write request), s_tuser[1] the command/data flag and
// s_tdata the byte to write. Every input transaction yields exactly one output
// transaction carrying the LCD pin levels after that item (data pins, low-pin drive,
// RS, RW, EN, busy and a refused-write flag).
// Results are registered; throughput is one item per cycle while s_tready is high, set
// by the single registered pass from the phase/countdown state to the output register.
// Strobe, gap and hold times count ticks, not clocks. The user must load the timing
// registers through cfg_we/cfg_index/cfg_wdata while idle; the block does not check.
// Reset puts the sequencer in its idle phase with 4-bit mode, EN low, pins low and the
// timing registers at their defaults; the output channel comes up empty.
// When the receiver stalls, one more result is held in a skid register; s_tready then
// drops until the output drains. No item is lost or repeated.
module char_lcd_write_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcdws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcdws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lcdws_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] byte_value
    input  logic [lcdws_pkg::S_USER_W-1:0]    s_tuser,   // [0] action, [1] is_data
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] data_pins, [8] low_pins_driven, [9] register_select, [10] read_write,
    // [11] enable_strobe, [12] busy_res, [13] write_refused, [15:14] zero
    output logic [lcdws_pkg::M_DATA_W-1:0]    m_tdata
);

`include "char_lcd_write_sequencer_assert.svh"

    lcdws_pkg::lcdws_result_t result;
    lcdws_pkg::lcdws_result_t out_reg;
    lcdws_pkg::lcdws_result_t skid_reg;
    logic                     out_valid_reg;
    logic                     skid_valid_reg;
    logic                     in_take;
    logic                     out_take;

    assign s_tready = ~skid_valid_reg;
    assign in_take  = s_tvalid & s_tready;
    assign out_take = out_valid_reg & m_tready;

    lcdws_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (in_take),
        .action      (s_tuser[0]),
        .byte_value  (s_tdata),
        .is_data     (s_tuser[1]),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `LCDWS_ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a result while the output register is empty")
    `LCDWS_ASSERT_NEXT(a_accept_gives_result, in_take, m_tvalid,
        "accepted transaction produced no output")
    `LCDWS_ASSERT_IMPLY(a_strobe_when_busy, out_valid_reg && out_reg.enable_strobe,
        out_reg.busy_res, "enable strobe high while not busy")
    `LCDWS_ASSERT_IMPLY(a_refused_when_busy, out_valid_reg && out_reg.write_refused,
        out_reg.busy_res, "write refused while idle")

endmodule

[sv/lcdws_ctrl.sv]
module lcdws_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lcdws_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcdws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              item_accept,
    input  logic                              action,
    input  logic [lcdws_pkg::BYTE_W-1:0]      byte_value,
    input  logic                              is_data,
    output lcdws_pkg::lcdws_result_t          result
);

    localparam int LW = (COUNT_WIDTH > lcdws_pkg::TICKS_W) ? COUNT_WIDTH : lcdws_pkg::TICKS_W;
    localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

    function automatic logic [COUNT_WIDTH-1:0] clamp_count(
        input logic [lcdws_pkg::TICKS_W-1:0] v
    );
        logic [LW-1:0] wide;
        wide = LW'(v);
        if (wide > CMAX)
        begin
            return CMAX[COUNT_WIDTH-1:0];
        end
        return wide[COUNT_WIDTH-1:0];
    endfunction

    logic                              four_bit_mode_reg;
    logic [lcdws_pkg::STROBE_W-1:0]    enable_high_ticks_reg;
    logic [lcdws_pkg::TICKS_W-1:0]     nibble_gap_ticks_reg;
    logic [lcdws_pkg::TICKS_W-1:0]     command_hold_ticks_reg;
    logic [lcdws_pkg::TICKS_W-1:0]     data_hold_ticks_reg;

    lcdws_pkg::lcdws_phase_t           phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]            count_reg, count_next;
    logic [lcdws_pkg::BYTE_W-1:0]      byte_reg, byte_next;
    logic                              select_reg, select_next;
    logic                              four_reg, four_next;
    logic [lcdws_pkg::BYTE_W-1:0]      pin_reg, pin_next;

    logic [COUNT_WIDTH-1:0]            en_cnt;
    logic [COUNT_WIDTH-1:0]            gap_cnt;
    logic [COUNT_WIDTH-1:0]            hold_cnt;
    logic [COUNT_WIDTH-1:0]            dec_cnt;
    logic [lcdws_pkg::BYTE_W-1:0]      low_pins;
    logic                              refused;
    logic                              busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_mode_reg      <= lcdws_pkg::RESET_FOUR_BIT_MODE;
            enable_high_ticks_reg  <= lcdws_pkg::RESET_ENABLE_HIGH_TICKS;
            nibble_gap_ticks_reg   <= lcdws_pkg::RESET_NIBBLE_GAP_TICKS;
            command_hold_ticks_reg <= lcdws_pkg::RESET_COMMAND_HOLD_TICKS;
            data_hold_ticks_reg    <= lcdws_pkg::RESET_DATA_HOLD_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcdws_pkg::REG_FOUR_BIT_MODE:      four_bit_mode_reg <= cfg_wdata[0];
                lcdws_pkg::REG_ENABLE_HIGH_TICKS:
                    enable_high_ticks_reg <= cfg_wdata[lcdws_pkg::STROBE_W-1:0];
                lcdws_pkg::REG_NIBBLE_GAP_TICKS:   nibble_gap_ticks_reg <= cfg_wdata;
                lcdws_pkg::REG_COMMAND_HOLD_TICKS: command_hold_ticks_reg <= cfg_wdata;
                lcdws_pkg::REG_DATA_HOLD_TICKS:    data_hold_ticks_reg <= cfg_wdata;
                default:                           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lcdws_pkg::PH_IDLE;
            count_reg  <= '0;
            byte_reg   <= '0;
            select_reg <= 1'b0;
            four_reg   <= 1'b1;
            pin_reg    <= '0;
        end
        else if (item_accept)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            byte_reg   <= byte_next;
            select_reg <= select_next;
            four_reg   <= four_next;
            pin_reg    <= pin_next;
        end
    end

    assign en_cnt   = (enable_high_ticks_reg == '0) ? COUNT_WIDTH'(1)
                                                    : COUNT_WIDTH'(enable_high_ticks_reg);
    assign gap_cnt  = clamp_count(nibble_gap_ticks_reg);
    assign hold_cnt = clamp_count(select_reg ? data_hold_ticks_reg : command_hold_ticks_reg);
    assign dec_cnt  = (count_reg == '0) ? '0 : count_reg - COUNT_WIDTH'(1);
    assign low_pins = lcdws_pkg::BYTE_W'((byte_reg & lcdws_pkg::LOW_NIBBLE) << 4);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        byte_next   = byte_reg;
        select_next = select_reg;
        four_next   = four_reg;
        pin_next    = pin_reg;
        refused     = 1'b0;

        if (action == lcdws_pkg::ACTION_WRITE)
        begin
            if (phase_reg != lcdws_pkg::PH_IDLE)
            begin
                refused = 1'b1;
            end
            else
            begin
                byte_next   = byte_value;
                select_next = is_data;
                four_next   = four_bit_mode_reg;
                pin_next    = four_bit_mode_reg ? (byte_value & lcdws_pkg::HIGH_NIBBLE)
                                                : byte_value;
                phase_next  = lcdws_pkg::PH_STROBE_HI;
                count_next  = en_cnt;
            end
        end
        else
        begin
            case (phase_reg)
                lcdws_pkg::PH_IDLE:
                begin
                end
                lcdws_pkg::PH_STROBE_HI,
                lcdws_pkg::PH_GAP,
                lcdws_pkg::PH_STROBE_LO,
                lcdws_pkg::PH_HOLD:
                begin
                    count_next = dec_cnt;
                    if (dec_cnt == '0)
                    begin
                        // advance; a zero gap or hold falls through to the next phase
                        if ((phase_reg == lcdws_pkg::PH_STROBE_HI && four_reg && gap_cnt == '0)
                            || phase_reg == lcdws_pkg::PH_GAP)
                        begin
                            phase_next = lcdws_pkg::PH_STROBE_LO;
                            pin_next   = low_pins;
                            count_next = en_cnt;
                        end
                        else if (phase_reg == lcdws_pkg::PH_STROBE_HI && four_reg)
                        begin
                            phase_next = lcdws_pkg::PH_GAP;
                            count_next = gap_cnt;
                        end
                        else if (phase_reg != lcdws_pkg::PH_HOLD && hold_cnt != '0)
                        begin
                            phase_next = lcdws_pkg::PH_HOLD;
                            count_next = hold_cnt;
                        end
                        else
                        begin
                            phase_next = lcdws_pkg::PH_IDLE;
                            count_next = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = lcdws_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign busy = (phase_next != lcdws_pkg::PH_IDLE);

    always_comb
    begin
        result                 = '0;
        result.data_pins       = pin_next;
        result.low_pins_driven = busy ? ~four_next : ~four_bit_mode_reg;
        result.register_select = select_next;
        result.read_write      = 1'b0;
        result.enable_strobe   = (phase_next == lcdws_pkg::PH_STROBE_HI)
                              || (phase_next == lcdws_pkg::PH_STROBE_LO);
        result.busy_res        = busy;
        result.write_refused   = refused;
    end

endmodule
